// ----- sv/ltc_pkg.sv -----
// Shared types, widths and defaults for the LRU tile cache tracker.
package ltc_pkg;

    localparam int CACHE_ENTRIES_DEF = 16;
    localparam int LAYER_COUNT_DEF   = 8;

    localparam int LAYER_W  = 3;
    localparam int LEVEL_W  = 5;
    localparam int ROW_W    = 16;
    localparam int COL_W    = 16;
    localparam int CAP_W    = 5;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;

    localparam int CAP_RESET = 16;

    typedef enum logic [STATUS_W-1:0] {
        ST_ABSENT = 2'd0,
        ST_HIT    = 2'd1,
        ST_MISS   = 2'd2
    } ltc_status_t;

    typedef struct packed {
        logic [LAYER_W-1:0] layer;
        logic [LEVEL_W-1:0] level;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
    } ltc_key_t;

    typedef struct packed {
        ltc_status_t status;
        logic        write;
        logic        fill;
        logic        evict;
    } ltc_decision_t;

endpackage

// ----- sv/ltc_req_if.sv -----
// Request channel: tile key and backing-store flag.
interface ltc_req_if
    import ltc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [LAYER_W-1:0] layer_index;
    logic [LEVEL_W-1:0] grid_level;
    logic [ROW_W-1:0]   grid_row;
    logic [COL_W-1:0]   grid_column;
    logic               tile_on_disk;

    modport source (
        output valid, layer_index, grid_level, grid_row, grid_column, tile_on_disk,
        input  ready
    );

    modport sink (
        input  valid, layer_index, grid_level, grid_row, grid_column, tile_on_disk,
        output ready
    );
endinterface

// ----- sv/ltc_rsp_if.sv -----
// Response channel: lookup status, slot and evicted key.
interface ltc_rsp_if
    import ltc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                evicted_valid;
    logic [LAYER_W-1:0]  evicted_layer;
    logic [LEVEL_W-1:0]  evicted_level;
    logic [ROW_W-1:0]    evicted_row;
    logic [COL_W-1:0]    evicted_column;

    modport source (
        output valid, status, slot, evicted_valid, evicted_layer, evicted_level,
               evicted_row, evicted_column,
        input  ready
    );

    modport sink (
        input  valid, status, slot, evicted_valid, evicted_layer, evicted_level,
               evicted_row, evicted_column,
        output ready
    );
endinterface

// ----- sv/ltc_lookup.sv -----
// Associative match, free-slot and LRU victim search, recency ageing mask.
module ltc_lookup
    import ltc_pkg::*;
#(
    parameter  int CACHE_ENTRIES = CACHE_ENTRIES_DEF,
    parameter  int LAYER_COUNT   = LAYER_COUNT_DEF,
    localparam int IDX_W         = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1,
    localparam int OCC_W         = $clog2(CACHE_ENTRIES + 1)
)
(
    input  ltc_key_t                             req_key,
    input  logic                                 on_disk,
    input  logic [CACHE_ENTRIES-1:0]             valid_vec,
    input  ltc_key_t                             key_arr [CACHE_ENTRIES],
    input  logic [CACHE_ENTRIES-1:0][IDX_W-1:0]  rank_arr,
    input  logic [OCC_W-1:0]                     occupancy,
    input  logic [OCC_W-1:0]                     capacity,
    output ltc_decision_t                        dec,
    output logic [IDX_W-1:0]                     slot_idx,
    output ltc_key_t                             victim_key,
    output logic [CACHE_ENTRIES-1:0]             age_vec
);

    logic [CACHE_ENTRIES-1:0] hit_vec;
    logic [CACHE_ENTRIES-1:0] lru_vec;
    logic [IDX_W-1:0]         hit_idx;
    logic [IDX_W-1:0]         free_idx;
    logic [IDX_W-1:0]         lru_idx;
    logic [IDX_W-1:0]         hit_rank;
    logic [OCC_W-1:0]         occ_m1;
    logic [OCC_W-1:0]         old_rank;
    logic                     present;
    logic                     hit;
    logic                     has_room;

    assign occ_m1   = occupancy - 1'b1;
    assign present  = on_disk && (int'(req_key.layer) < LAYER_COUNT);
    assign hit      = |hit_vec;
    assign has_room = occupancy < capacity;

    always_comb
    begin
        hit_idx    = '0;
        free_idx   = '0;
        lru_idx    = '0;
        hit_rank   = '0;
        victim_key = '0;
        for (int i = 0; i < CACHE_ENTRIES; i++)
        begin
            hit_vec[i] = valid_vec[i] && (key_arr[i] == req_key);
            lru_vec[i] = valid_vec[i] && (rank_arr[i] == occ_m1[IDX_W-1:0]);
            if (hit_vec[i])
                hit_rank = hit_rank | rank_arr[i];
            if (lru_vec[i])
                victim_key = victim_key | key_arr[i];
        end
        // lowest index wins
        for (int i = CACHE_ENTRIES - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
                hit_idx = IDX_W'(i);
            if (!valid_vec[i])
                free_idx = IDX_W'(i);
            if (lru_vec[i])
                lru_idx = IDX_W'(i);
        end
    end

    always_comb
    begin
        dec      = '{status: ST_ABSENT, write: 1'b0, fill: 1'b0, evict: 1'b0};
        slot_idx = '0;
        old_rank = '0;
        if (present)
        begin
            dec.write = 1'b1;
            if (hit)
            begin
                dec.status = ST_HIT;
                slot_idx   = hit_idx;
                old_rank   = OCC_W'(hit_rank);
            end
            else if (has_room)
            begin
                dec.status = ST_MISS;
                dec.fill   = 1'b1;
                slot_idx   = free_idx;
                old_rank   = occupancy;
            end
            else
            begin
                dec.status = ST_MISS;
                dec.evict  = 1'b1;
                slot_idx   = lru_idx;
                old_rank   = occ_m1;
            end
        end
    end

    // entries more recent than the promoted one age by one
    always_comb
    begin
        for (int i = 0; i < CACHE_ENTRIES; i++)
            age_vec[i] = valid_vec[i] && (IDX_W'(i) != slot_idx)
                         && (OCC_W'(rank_arr[i]) < old_rank);
    end

endmodule

// ----- sv/ltc_directory.sv -----
// Directory state: valid bits, keys, recency ranks, occupancy and capacity.
module ltc_directory
    import ltc_pkg::*;
#(
    parameter  int CACHE_ENTRIES = CACHE_ENTRIES_DEF,
    localparam int IDX_W         = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1,
    localparam int OCC_W         = $clog2(CACHE_ENTRIES + 1)
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [CAP_W-1:0]                     cfg_wdata,
    input  logic                                 upd_en,
    input  ltc_decision_t                        dec,
    input  logic [IDX_W-1:0]                     slot_idx,
    input  logic [CACHE_ENTRIES-1:0]             age_vec,
    input  ltc_key_t                             req_key,
    output logic [CACHE_ENTRIES-1:0]             valid_vec,
    output ltc_key_t                             key_arr [CACHE_ENTRIES],
    output logic [CACHE_ENTRIES-1:0][IDX_W-1:0]  rank_arr,
    output logic [OCC_W-1:0]                     occupancy,
    output logic [OCC_W-1:0]                     capacity
);

    localparam int CAP_RST = (CAP_RESET > CACHE_ENTRIES) ? CACHE_ENTRIES : CAP_RESET;

    logic [CACHE_ENTRIES-1:0]            valid_reg, valid_next;
    logic [CACHE_ENTRIES-1:0][IDX_W-1:0] rank_reg, rank_next;
    logic [OCC_W-1:0]                    occ_reg, occ_next;
    logic [OCC_W-1:0]                    cap_reg, cap_next;
    ltc_key_t                            key_reg [CACHE_ENTRIES];
    logic                                key_we;
    int                                  cap_eff;

    assign key_we = !cfg_we && upd_en && dec.write;

    always_comb
    begin
        cap_eff = int'(cfg_wdata);
        if (cap_eff < 1)
            cap_eff = 1;
        if (cap_eff > CACHE_ENTRIES)
            cap_eff = CACHE_ENTRIES;
    end

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        occ_next   = occ_reg;
        cap_next   = cap_reg;
        if (cfg_we)
        begin
            valid_next = '0;
            rank_next  = '0;
            occ_next   = '0;
            cap_next   = OCC_W'(cap_eff);
        end
        else if (upd_en && dec.write)
        begin
            for (int i = 0; i < CACHE_ENTRIES; i++)
            begin
                if (age_vec[i])
                    rank_next[i] = rank_reg[i] + 1'b1;
            end
            rank_next[slot_idx]  = '0;
            valid_next[slot_idx] = 1'b1;
            if (dec.fill)
                occ_next = occ_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rank_reg  <= '0;
            occ_reg   <= '0;
            cap_reg   <= OCC_W'(CAP_RST);
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            occ_reg   <= occ_next;
            cap_reg   <= cap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
            key_reg[slot_idx] <= req_key;
    end

    assign valid_vec = valid_reg;
    assign key_arr   = key_reg;
    assign rank_arr  = rank_reg;
    assign occupancy = occ_reg;
    assign capacity  = cap_reg;

endmodule

// ----- sv/lru_tile_cache_tracker_core.sv -----
// Top level of the fully associative LRU tile cache tracker.
// Takes one item per cycle. An accepted item is held in an input register; while it sits
// there all directory keys are compared in parallel, the free or least recent slot is
// chosen and the recency ranks are computed. When the item advances, the result is
// registered together with the directory update and offered on the response channel.
// The input register keeps accepting while a finished result waits, and only stalls
// when both registers are full and the response is not taken. A write to the capacity
// register clears the whole directory; write it only while idle.
module lru_tile_cache_tracker_core
    import ltc_pkg::*;
#(
    parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF,
    parameter int LAYER_COUNT   = LAYER_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CAP_W-1:0]  cfg_wdata,
    ltc_req_if.sink           req,
    ltc_rsp_if.source         rsp
);

    localparam int IDX_W  = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int OCC_W  = $clog2(CACHE_ENTRIES + 1);
    localparam int WIDE_W = IDX_W + SLOT_W;

    logic                                in_valid_reg, in_valid_next;
    ltc_key_t                            in_key_reg;
    logic                                in_on_disk_reg;
    logic                                out_valid_reg, out_valid_next;
    ltc_status_t                         out_status_reg, out_status_next;
    logic [SLOT_W-1:0]                   out_slot_reg, out_slot_next;
    logic                                out_evict_reg, out_evict_next;
    ltc_key_t                            out_victim_reg, out_victim_next;

    logic                                accept;
    logic                                advance;
    ltc_key_t                            req_key;
    ltc_decision_t                       dec;
    logic [IDX_W-1:0]                    slot_idx;
    logic [WIDE_W-1:0]                   slot_wide;
    ltc_key_t                            victim_key;
    logic [CACHE_ENTRIES-1:0]            age_vec;
    logic [CACHE_ENTRIES-1:0]            valid_vec;
    ltc_key_t                            key_arr [CACHE_ENTRIES];
    logic [CACHE_ENTRIES-1:0][IDX_W-1:0] rank_arr;
    logic [OCC_W-1:0]                    occupancy;
    logic [OCC_W-1:0]                    capacity;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign accept    = req.valid && req.ready;

    assign req_key = '{layer: req.layer_index, level: req.grid_level,
                       row: req.grid_row, col: req.grid_column};

    ltc_lookup #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .LAYER_COUNT   (LAYER_COUNT)
    ) u_lookup (
        .req_key    (in_key_reg),
        .on_disk    (in_on_disk_reg),
        .valid_vec  (valid_vec),
        .key_arr    (key_arr),
        .rank_arr   (rank_arr),
        .occupancy  (occupancy),
        .capacity   (capacity),
        .dec        (dec),
        .slot_idx   (slot_idx),
        .victim_key (victim_key),
        .age_vec    (age_vec)
    );

    ltc_directory #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_directory (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .upd_en    (advance),
        .dec       (dec),
        .slot_idx  (slot_idx),
        .age_vec   (age_vec),
        .req_key   (in_key_reg),
        .valid_vec (valid_vec),
        .key_arr   (key_arr),
        .rank_arr  (rank_arr),
        .occupancy (occupancy),
        .capacity  (capacity)
    );

    assign slot_wide = WIDE_W'(slot_idx);

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_evict_next  = out_evict_reg;
        out_victim_next = out_victim_reg;
        if (advance)
        begin
            out_valid_next  = 1'b1;
            out_status_next = dec.status;
            out_slot_next   = slot_wide[SLOT_W-1:0];
            out_evict_next  = dec.evict;
            out_victim_next = dec.evict ? victim_key : '0;
        end
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_key_reg     <= req_key;
            in_on_disk_reg <= req.tile_on_disk;
        end
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_evict_reg  <= out_evict_next;
        out_victim_reg <= out_victim_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.slot           = out_slot_reg;
    assign rsp.evicted_valid  = out_evict_reg;
    assign rsp.evicted_layer  = out_victim_reg.layer;
    assign rsp.evicted_level  = out_victim_reg.level;
    assign rsp.evicted_row    = out_victim_reg.row;
    assign rsp.evicted_column = out_victim_reg.col;

endmodule

// ----- tb/tb_lru_tile_cache_tracker_core.sv -----
// Self-checking testbench for the LRU tile cache tracker: directory predictor, random handshakes.
`timescale 1ns / 1ps

module tb_lru_tile_cache_tracker_core
    import ltc_pkg::*;
;

    localparam int CLK_HALF    = 6;
    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_HOLD   = 48;
    localparam int MAX_PRINTS  = 40;

    typedef struct packed {
        ltc_status_t       status;
        logic [SLOT_W-1:0] slot;
        logic              evicted_valid;
        ltc_key_t          evicted_key;
    } lookup_result_t;

    class tile_cache_scoreboard;
        bit               entry_valid [CACHE_ENTRIES_DEF];
        ltc_key_t         entry_key   [CACHE_ENTRIES_DEF];
        int unsigned      rank        [CACHE_ENTRIES_DEF];
        int unsigned      occupancy;
        logic [CAP_W-1:0] capacity;
        lookup_result_t   expected_lookups [$];
        int               errors;

        function new();
            capacity = CAP_RESET;
            errors   = 0;
            flush();
        endfunction

        function void flush();
            foreach (entry_valid[i])
            begin
                entry_valid[i] = 1'b0;
                entry_key[i]   = '0;
                rank[i]        = 0;
            end
            occupancy = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] value);
            capacity = value;
            flush();
        endfunction

        function int unsigned usable_capacity();
            if (capacity == 0)
                return 1;
            if (capacity > CACHE_ENTRIES_DEF)
                return CACHE_ENTRIES_DEF;
            return capacity;
        endfunction

        // entries more recent than s age by one, s becomes rank 0
        function void make_recent(int s);
            int unsigned old_rank;
            old_rank = rank[s];
            foreach (rank[i])
            begin
                if (i != s && entry_valid[i] && rank[i] < old_rank)
                    rank[i]++;
            end
            rank[s] = 0;
        endfunction

        function void note_request(ltc_key_t k, logic on_disk);
            lookup_result_t r;
            int             hit_slot;
            int             s;
            int unsigned    worst;
            r        = '0;
            r.status = ST_ABSENT;
            hit_slot = -1;
            s        = -1;
            worst    = 0;
            if (on_disk && k.layer < LAYER_COUNT_DEF)
            begin
                foreach (entry_valid[i])
                begin
                    if (hit_slot < 0 && entry_valid[i] && entry_key[i] == k)
                        hit_slot = i;
                end
                if (hit_slot >= 0)
                begin
                    make_recent(hit_slot);
                    r.status = ST_HIT;
                    r.slot   = hit_slot[SLOT_W-1:0];
                end
                else
                begin
                    if (occupancy < usable_capacity())
                    begin
                        foreach (entry_valid[i])
                        begin
                            if (s < 0 && !entry_valid[i])
                                s = i;
                        end
                        rank[s]        = occupancy;
                        entry_valid[s] = 1'b1;
                        occupancy++;
                    end
                    else
                    begin
                        foreach (entry_valid[i])
                        begin
                            if (entry_valid[i] && (s < 0 || rank[i] > worst))
                            begin
                                worst = rank[i];
                                s     = i;
                            end
                        end
                        r.evicted_valid = 1'b1;
                        r.evicted_key   = entry_key[s];
                    end
                    entry_key[s] = k;
                    make_recent(s);
                    r.status = ST_MISS;
                    r.slot   = s[SLOT_W-1:0];
                end
            end
            expected_lookups = {expected_lookups, r};
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTS)
                $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        task compare_field(string name, longint unsigned got, longint unsigned want);
            if (got != want)
                report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
        endtask

        task check_response(lookup_result_t got);
            lookup_result_t want;
            if (expected_lookups.size() == 0)
            begin
                report("response with no request outstanding");
                return;
            end
            want = expected_lookups.pop_front();
            compare_field("status", got.status, want.status);
            compare_field("slot", got.slot, want.slot);
            compare_field("evicted_valid", got.evicted_valid, want.evicted_valid);
            compare_field("evicted_layer", got.evicted_key.layer, want.evicted_key.layer);
            compare_field("evicted_level", got.evicted_key.level, want.evicted_key.level);
            compare_field("evicted_row", got.evicted_key.row, want.evicted_key.row);
            compare_field("evicted_column", got.evicted_key.col, want.evicted_key.col);
        endtask

        task check_drained();
            if (expected_lookups.size() != 0)
                report($sformatf("%0d responses never arrived", expected_lookups.size()));
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_wdata;

    ltc_req_if req_ch ();
    ltc_rsp_if rsp_ch ();

    lru_tile_cache_tracker_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    tile_cache_scoreboard sb = new();

    bit       idle_on = 1'b1;
    bit       long_hold_req = 1'b0;
    int       hold_left = 0;
    ltc_key_t key_pool [$];

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    always @(posedge clk)
    begin : response_sink
        lookup_result_t got;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                got.status                = ltc_status_t'(rsp_ch.status);
                got.slot                  = rsp_ch.slot;
                got.evicted_valid         = rsp_ch.evicted_valid;
                got.evicted_key.layer     = rsp_ch.evicted_layer;
                got.evicted_key.level     = rsp_ch.evicted_level;
                got.evicted_key.row       = rsp_ch.evicted_row;
                got.evicted_key.col       = rsp_ch.evicted_column;
                sb.check_response(got);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                hold_left = $urandom_range(0, 4);
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic ltc_key_t tile_key(int layer, int level, int row, int col);
        ltc_key_t k;
        k.layer = layer[LAYER_W-1:0];
        k.level = level[LEVEL_W-1:0];
        k.row   = row[ROW_W-1:0];
        k.col   = col[COL_W-1:0];
        return k;
    endfunction

    function automatic ltc_key_t random_tile();
        return tile_key($urandom_range(0, 7), $urandom_range(0, 31),
                        $urandom_range(0, 65535), $urandom_range(0, 65535));
    endfunction

    task automatic offer_tile(ltc_key_t k, logic on_disk);
        req_ch.valid        <= 1'b1;
        req_ch.layer_index  <= k.layer;
        req_ch.grid_level   <= k.level;
        req_ch.grid_row     <= k.row;
        req_ch.grid_column  <= k.col;
        req_ch.tile_on_disk <= on_disk;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        sb.note_request(k, on_disk);
    endtask

    task automatic maybe_gap();
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // stop offering, wait for every outstanding response plus pipeline slack
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (sb.expected_lookups.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_capacity(value);
    endtask

    task automatic run_phase(logic [CAP_W-1:0] cap, int items, bit stall_receiver,
                             bit drain_midway);
        int       pool_size;
        int       pick;
        ltc_key_t k;
        logic     on_disk;
        write_capacity(cap);
        pool_size = int'(cap) + $urandom_range(1, 4);
        if (pool_size > 20)
            pool_size = 20;
        key_pool.delete();
        repeat (pool_size) key_pool = {key_pool, random_tile()};
        for (int n = 0; n < items; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
                key_pool[$urandom_range(0, key_pool.size() - 1)] = random_tile();
            if (pick >= 94)
                k = random_tile();
            else
                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            on_disk = ($urandom_range(0, 9) != 0);
            if (stall_receiver && n == items / 4)
                long_hold_req = 1'b1;
            if (drain_midway && n == items / 2)
                settle();
            offer_tile(k, on_disk);
            maybe_gap();
        end
    endtask

    initial
    begin : stimulus
        ltc_key_t k_lo;
        ltc_key_t k_hi;
        ltc_key_t k_a;
        ltc_key_t k_b;
        ltc_key_t k_c;
        k_lo = '0;
        k_hi = '1;
        k_a  = tile_key(1, 2, 3, 4);
        k_b  = tile_key(6, 17, 16'h8000, 16'h0001);
        k_c  = tile_key(3, 10, 16'h1234, 16'hABCD);

        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= '0;
        req_ch.valid        <= 1'b0;
        req_ch.layer_index  <= '0;
        req_ch.grid_level   <= '0;
        req_ch.grid_row     <= '0;
        req_ch.grid_column  <= '0;
        req_ch.tile_on_disk <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset capacity: extremes, absent tiles, hits
        offer_tile(k_lo, 1'b1);
        offer_tile(k_hi, 1'b1);
        offer_tile(k_hi, 1'b0);
        offer_tile(k_lo, 1'b1);
        offer_tile(k_hi, 1'b1);
        offer_tile(k_lo, 1'b0);
        offer_tile(k_c, 1'b1);
        offer_tile(k_hi, 1'b1);

        // capacity zero acts as one
        write_capacity(5'd0);
        offer_tile(k_a, 1'b1);
        offer_tile(k_b, 1'b1);
        offer_tile(k_b, 1'b1);
        offer_tile(k_a, 1'b0);
        offer_tile(k_a, 1'b1);

        // two entries: hit refreshes recency, least recent goes
        write_capacity(5'd2);
        offer_tile(k_a, 1'b1);
        offer_tile(k_b, 1'b1);
        offer_tile(k_a, 1'b1);
        offer_tile(k_c, 1'b1);
        offer_tile(k_a, 1'b1);
        offer_tile(k_b, 1'b1);

        run_phase(5'd31, 215, 1'b0, 1'b0);
        run_phase(5'd1,  215, 1'b1, 1'b0);
        run_phase(5'd17, 215, 1'b0, 1'b1);
        run_phase(5'd0,  175, 1'b0, 1'b0);
        run_phase(5'd4,  215, 1'b1, 1'b0);
        run_phase(5'd12, 215, 1'b0, 1'b0);
        run_phase(5'd2,  215, 1'b0, 1'b1);
        run_phase(5'd8,  215, 1'b0, 1'b0);
        idle_on = 1'b0;
        run_phase(5'd16, 250, 1'b0, 1'b0);

        settle();
        repeat (4) @(posedge clk);
        sb.check_drained();
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/ltc_pkg.sv
sv/ltc_req_if.sv
sv/ltc_rsp_if.sv
sv/ltc_lookup.sv
sv/ltc_directory.sv
sv/lru_tile_cache_tracker_core.sv
tb/tb_lru_tile_cache_tracker_core.sv
